[rtl/dcfs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// DAC frame sequencer package
// Word types, job record and frame command bytes shared by the sequencer.
// ----------------------------------------------------------------------------
package dcfs_pkg;

	typedef struct packed {
		logic [7:0] target_device;
		logic [7:0] packet_length;
		logic [7:0] channel;
		logic [7:0] range_or_opcode;
		logic [7:0] data_high;
		logic [7:0] data_low;
	} in_word_t;

	typedef struct packed {
		logic [23:0] frame;
		logic        last_frame;
	} out_word_t;

	// Frame slots of one job, in emission order
	localparam int unsigned NUM_SLOTS = 6;
	typedef logic [NUM_SLOTS-1:0] slot_mask_t;
	typedef logic [2:0]           slot_idx_t;

	localparam slot_idx_t SLOT_SETUP_REF   = 3'd0;
	localparam slot_idx_t SLOT_SETUP_CTRL  = 3'd1;
	localparam slot_idx_t SLOT_SETUP_POWER = 3'd2;
	localparam slot_idx_t SLOT_RANGE       = 3'd3;
	localparam slot_idx_t SLOT_POWER       = 3'd4;
	localparam slot_idx_t SLOT_DATA        = 3'd5;

	// Everything the back end needs to build the frames of one packet
	typedef struct packed {
		slot_mask_t mask;
		logic       chan;
		logic [2:0] range_code;
		logic [7:0] setup_pwr;
		logic [7:0] cmd_pwr;
		logic [7:0] data_high;
		logic [7:0] data_low;
	} job_t;

	localparam logic [7:0] MIN_PACKET_LEN  = 8'd7;
	localparam logic [7:0] OP_POWER        = 8'h10;
	localparam logic [7:0] MAX_RANGE_CODE  = 8'd5;
	localparam logic [7:0] ARG_POWER_ON    = 8'h11;
	localparam logic [7:0] ARG_POWER_OFF   = 8'h00;
	localparam logic [7:0] PWR_RESET       = 8'b0001_0000;
	localparam logic [7:0] PWR_BIT_CH0     = 8'b0000_0001;
	localparam logic [7:0] PWR_BIT_CH1     = 8'b0000_0100;

	localparam logic [7:0] CMD_SETUP_REF   = 8'h19;
	localparam logic [7:0] ARG_SETUP_REF   = 8'h0D;
	localparam logic [7:0] CMD_SETUP_CTRL  = 8'h0C;
	localparam logic [7:0] CMD_POWER       = 8'h10;
	localparam logic [7:0] CMD_RANGE_CH0   = 8'h08;
	localparam logic [7:0] CMD_RANGE_CH1   = 8'h0A;
	localparam logic [7:0] CMD_DATA_CH0    = 8'h00;
	localparam logic [7:0] CMD_DATA_CH1    = 8'h02;

endpackage
`default_nettype wire

[rtl/dcfs_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// DAC frame sequencer front end
// Filters packets, tracks DAC power and range state, and builds one job.
// ----------------------------------------------------------------------------
module dcfs_front import dcfs_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic      accept,
	input  wire in_word_t  in_word,
	output logic           push,
	output job_t           job
);

	logic [7:0] device_code_q;
	logic       setup_done_q;
	logic [7:0] pwr_q;
	logic [2:0] range_q   [2];
	logic       powered_q [2];

	logic       hit, ch, is_pwr, is_range, pwr_arg_ok, range_chg, do_power, pwr_set;
	logic [7:0] pwr_bit, pwr_new;

	always_comb begin
		hit        = (in_word.target_device == device_code_q) &&
		             (in_word.packet_length >= MIN_PACKET_LEN) &&
		             (in_word.channel[7:1] == 7'd0);
		ch         = in_word.channel[0];
		pwr_bit    = ch ? PWR_BIT_CH1 : PWR_BIT_CH0;
		is_pwr     = (in_word.range_or_opcode == OP_POWER);
		is_range   = (in_word.range_or_opcode <= MAX_RANGE_CODE);
		pwr_arg_ok = (in_word.data_high == ARG_POWER_ON) ||
		             (in_word.data_high == ARG_POWER_OFF);
		range_chg  = is_range && (in_word.range_or_opcode[2:0] != range_q[ch]);
		do_power   = (is_pwr && pwr_arg_ok) || (is_range && !powered_q[ch]);
		// range writes always power up; power command follows its argument
		pwr_set    = is_pwr ? (in_word.data_high == ARG_POWER_ON) : 1'b1;
		pwr_new    = pwr_set ? (pwr_q | pwr_bit) : (pwr_q & ~pwr_bit);

		job.mask       = {is_range, do_power, range_chg, {3{!setup_done_q}}};
		job.chan       = ch;
		job.range_code = in_word.range_or_opcode[2:0];
		job.setup_pwr  = pwr_q;
		job.cmd_pwr    = pwr_new;
		job.data_high  = in_word.data_high;
		job.data_low   = in_word.data_low;

		// drop packets that cause no frames
		push = accept && hit && (job.mask != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_code_q <= '0;
			setup_done_q  <= 1'b0;
			pwr_q         <= PWR_RESET;
			range_q[0]    <= '0;
			range_q[1]    <= '0;
			powered_q[0]  <= 1'b0;
			powered_q[1]  <= 1'b0;
		end else begin
			if (cfg_we) begin
				device_code_q <= cfg_wdata;
			end
			if (accept && hit) begin
				setup_done_q <= 1'b1;
				if (do_power) begin
					pwr_q         <= pwr_new;
					powered_q[ch] <= pwr_set;
				end
				if (is_range) begin
					range_q[ch] <= in_word.range_or_opcode[2:0];
				end
			end
		end
	end

endmodule
`default_nettype wire

[rtl/dcfs_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// DAC frame sequencer job queue
// Small FIFO of jobs between the front end and the frame builder.
// ----------------------------------------------------------------------------
module dcfs_queue import dcfs_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output logic      full,
	output logic      empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	job_t          mem [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/dcfs_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// DAC frame sequencer back end
// Walks the frame slots of each job and drives the registered output word.
// ----------------------------------------------------------------------------
module dcfs_back import dcfs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t head,
	input  wire logic empty,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_word_t out_word
);

	slot_mask_t mask_q, rest;
	job_t       job_q;
	logic       out_valid_q;
	out_word_t  out_word_q;
	slot_idx_t  sel;
	logic [23:0] frame;
	logic       can_load, emit, need_load;

	// lowest pending slot goes first
	always_comb begin
		sel = SLOT_DATA;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = slot_idx_t'(i);
			end
		end
		rest = mask_q & ~(slot_mask_t'(1) << sel);
	end

	always_comb begin
		unique case (sel)
			SLOT_SETUP_REF:   frame = {CMD_SETUP_REF, 8'h00, ARG_SETUP_REF};
			SLOT_SETUP_CTRL:  frame = {CMD_SETUP_CTRL, 16'h0000};
			SLOT_SETUP_POWER: frame = {CMD_POWER, 8'h00, job_q.setup_pwr};
			SLOT_RANGE:       frame = {job_q.chan ? CMD_RANGE_CH1 : CMD_RANGE_CH0,
			                           8'h00, 5'd0, job_q.range_code};
			SLOT_POWER:       frame = {CMD_POWER, 8'h00, job_q.cmd_pwr};
			SLOT_DATA:        frame = {job_q.chan ? CMD_DATA_CH1 : CMD_DATA_CH0,
			                           job_q.data_high, job_q.data_low};
			default:          frame = '0;
		endcase
	end

	assign can_load  = !out_valid_q || !out_stall;
	assign emit      = (mask_q != '0) && can_load;
	assign need_load = (mask_q == '0) || (emit && (rest == '0));
	assign pop       = need_load && !empty;

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (emit) begin
			out_word_q.frame      <= frame;
			out_word_q.last_frame <= (rest == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mask_q <= head.mask;
			end else if (emit) begin
				mask_q <= rest;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
`default_nettype wire

[rtl/dac_command_frame_sequencer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// DAC command frame sequencer
// Turns host command packets for a two-channel DAC into 24-bit serial frames.
// ----------------------------------------------------------------------------
// Usage:
//  - in channel: one packet word per in_valid/in_stall handshake. in_stall is
//    high only while the job queue is full, so packets flow one per cycle.
//  - out channel: one frame word per handshake; last_frame marks the final
//    frame of a packet. Packets that cause no frames produce no word.
//  - cfg_we/cfg_wdata write the device code; write it only while idle.
//  - When the builder is idle, an accepted packet's job passes through the queue,
//    the job load from the queue and then the output register before its first frame.
//  - Throughput: the frame builder emits one frame per cycle while out_stall does
//    not hold it; a packet has 1 to 6 frames (up to 3 setup, range, power, data).
//  - Receiver stall: the output register holds its word; the builder and
//    then the queue fill, after which in_stall rises.
//  - Reset: state returns to the power-on defaults (device code 0, setup
//    frames due, reference on, both channels off and in range 0).
// ----------------------------------------------------------------------------
module dac_command_frame_sequencer_unit import dcfs_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_word_t   in_word,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_word_t       out_word
);

	logic accept, push, pop, full, empty;
	job_t push_job, head;

	// stall the host only when no job slot is free
	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	// classify packets and advance DAC state at acceptance
	dcfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.in_word   (in_word),
		.push      (push),
		.job       (push_job)
	);

	// decouple packet intake from frame emission
	dcfs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	// emit the frames of each job, one per cycle while the output is not stalled
	dcfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule
`default_nettype wire

[rtl/dcfs_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// DAC frame sequencer checker
// Port-level checks on frame ordering marks and output hold.
// ----------------------------------------------------------------------------
module dcfs_checker import dcfs_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire out_word_t  out_word
);

	// hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled output word changed");

	// data write always closes a packet
	a_data_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.frame[23:16] == CMD_DATA_CH0 ||
		              out_word.frame[23:16] == CMD_DATA_CH1) |-> out_word.last_frame)
		else $error("data frame not marked last");

	// range frames carry a valid code and are never last
	a_range_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.frame[23:16] == CMD_RANGE_CH0 ||
		              out_word.frame[23:16] == CMD_RANGE_CH1)
		|-> !out_word.last_frame && out_word.frame[15:3] == 13'd0 &&
		    out_word.frame[2:0] <= 3'd5)
		else $error("bad range frame");

	// setup reference and control frames are fixed and never last
	a_setup_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.frame[23:16] == CMD_SETUP_REF ||
		              out_word.frame[23:16] == CMD_SETUP_CTRL)
		|-> !out_word.last_frame &&
		    (out_word.frame == {CMD_SETUP_REF, 8'h00, ARG_SETUP_REF} ||
		     out_word.frame == {CMD_SETUP_CTRL, 16'h0000}))
		else $error("bad setup frame");

endmodule

bind dac_command_frame_sequencer_unit dcfs_checker u_dcfs_checker (.*);
`default_nettype wire
